/* src/smd_pkg.sv */
// Shared types and constants for the SSH mpint stream decoder.
// No dependencies; imported by every module of the block.
package smd_pkg;

    // Destination size limit and field widths
    localparam int MAX_DIGITS = 512;
    localparam int CAP_W      = 10;
    localparam int IDX_W      = 9;
    localparam int LEN_W      = 32;

    // Top bit of the first payload byte marks a negative value
    localparam logic [7:0] SIGN_MASK = 8'h80;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_NEG     = 3'd2,
        ST_NONMIN  = 3'd3,
        ST_TOOMANY = 3'd4
    } status_t;

    typedef enum logic {
        PH_LEN = 1'b0,
        PH_PAY = 1'b1
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_first;
        logic       buffer_end;
    } smd_in_t;

    typedef struct packed {
        logic             digit_valid;
        logic [IDX_W-1:0] digit_index;
        logic [7:0]       digit_value;
        logic             field_done;
        status_t          status;
    } smd_out_t;

    // Handshake between the parse step and the output register
    typedef struct packed {
        logic step;
        logic emit;
    } smd_ctl_t;

endpackage

/* src/smd_in_stage.sv */
// Input register for the mpint decoder: holds one word until the parse step takes it.
// Depends on smd_pkg.
module smd_in_stage
    import smd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  smd_in_t in_word,
    input  logic    step,
    output logic    held_valid,
    output smd_in_t held_word
);

    logic    valid_reg;
    smd_in_t word_reg;

    // Free when empty or when the held word moves on this cycle
    assign in_ready   = !valid_reg || step;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (step)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

/* src/smd_parse.sv */
// Parse state and per-byte decode: length gathering, sign/minimality/capacity checks,
// digit index generation and field status. Depends on smd_pkg.
module smd_parse
    import smd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             step,
    input  smd_in_t          item,
    output logic             emit,
    output smd_out_t         result
);

    // State registers
    phase_t           phase_reg,  phase_next;
    logic [1:0]       lbc_reg,    lbc_next;
    logic [LEN_W-1:0] rem_reg,    rem_next;
    logic [1:0]       pos_reg,    pos_next;
    logic             fwz_reg,    fwz_next;
    logic [CAP_W-1:0] ndi_reg,    ndi_next;
    logic             sticky_reg, sticky_next;
    status_t          pend_reg,   pend_next;
    logic [CAP_W-1:0] cap_reg;

    // Working copies after an optional buffer restart
    phase_t           ph;
    logic [1:0]       lbc;
    logic [LEN_W-1:0] rem;
    logic [1:0]       pos;
    logic             fwz;
    logic [CAP_W-1:0] ndi;
    logic             sticky;
    status_t          pend;

    logic [CAP_W-1:0] cap_eff;
    logic             cap_zero;
    logic             too_many;
    logic             give;
    logic             start;
    logic             open;
    logic             done;
    status_t          st;
    logic [CAP_W-1:0] idx_use;
    logic [7:0]       b;

    assign b        = item.data_byte;
    assign cap_eff  = (cap_reg > CAP_W'(MAX_DIGITS)) ? CAP_W'(MAX_DIGITS) : cap_reg;
    assign cap_zero = (cap_eff == '0);
    assign too_many = (rem > LEN_W'(cap_eff));

    // One byte of decode
    always_comb
    begin
        ph     = item.buffer_first ? PH_LEN : phase_reg;
        lbc    = item.buffer_first ? 2'd0 : lbc_reg;
        rem    = item.buffer_first ? '0 : rem_reg;
        pos    = item.buffer_first ? 2'd0 : pos_reg;
        fwz    = item.buffer_first ? 1'b0 : fwz_reg;
        ndi    = item.buffer_first ? '0 : ndi_reg;
        sticky = item.buffer_first ? 1'b0 : sticky_reg;
        pend   = item.buffer_first ? ST_OK : pend_reg;

        phase_next  = ph;
        lbc_next    = lbc;
        rem_next    = rem;
        pos_next    = pos;
        fwz_next    = fwz;
        ndi_next    = ndi;
        sticky_next = sticky;
        pend_next   = pend;

        give    = 1'b0;
        start   = 1'b0;
        open    = 1'b1;
        done    = 1'b0;
        st      = ST_OK;
        emit    = 1'b0;
        idx_use = ndi;

        if (!sticky)
        begin
            if (ph == PH_LEN)
            begin
                // Big-endian length, four bytes
                rem_next = {rem[LEN_W-9:0], b};
                lbc_next = lbc + 2'd1;
                if (lbc == 2'd3)
                begin
                    if (rem_next == '0)
                    begin
                        done = 1'b1;
                        st   = cap_zero ? ST_TOOMANY : ST_OK;
                        open = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                        pos_next   = 2'd0;
                        fwz_next   = 1'b0;
                        pend_next  = ST_OK;
                    end
                end
            end
            else
            begin
                // Payload byte; rem counts this byte too
                if (pos == 2'd0)
                begin
                    fwz_next = (b == 8'h00);
                    if ((b & SIGN_MASK) != 8'h00)
                    begin
                        pend_next = ST_NEG;
                    end
                    else if (b != 8'h00)
                    begin
                        if (too_many)
                        begin
                            pend_next = ST_TOOMANY;
                        end
                        else
                        begin
                            give  = 1'b1;
                            start = 1'b1;
                        end
                    end
                end
                else if (pend == ST_OK)
                begin
                    if (pos == 2'd1 && fwz)
                    begin
                        // Leading zero only allowed ahead of a set top bit
                        if ((b & SIGN_MASK) == 8'h00)
                        begin
                            pend_next = ST_NONMIN;
                        end
                        else if (too_many)
                        begin
                            pend_next = ST_TOOMANY;
                        end
                        else
                        begin
                            give  = 1'b1;
                            start = 1'b1;
                        end
                    end
                    else
                    begin
                        give = 1'b1;
                    end
                end

                if (pos != 2'd2)
                begin
                    pos_next = pos + 2'd1;
                end

                // Right-align the value in the destination
                if (start)
                begin
                    idx_use = cap_eff - rem[CAP_W-1:0];
                end
                if (give)
                begin
                    ndi_next = idx_use + CAP_W'(1);
                end

                rem_next = rem - LEN_W'(1);
                if (rem_next == '0)
                begin
                    done = 1'b1;
                    st   = pend_next;
                    if (st == ST_OK && cap_zero)
                    begin
                        st = ST_TOOMANY;
                    end
                    if (st != ST_OK)
                    begin
                        give = 1'b0;
                    end
                    open = 1'b0;
                end
            end

            // Field closed, buffer ran out, or plain digit
            if (!open)
            begin
                emit = 1'b1;
                if (st != ST_OK)
                begin
                    sticky_next = 1'b1;
                end
                phase_next = PH_LEN;
                lbc_next   = 2'd0;
                rem_next   = '0;
                pos_next   = 2'd0;
                fwz_next   = 1'b0;
                ndi_next   = '0;
                pend_next  = ST_OK;
            end
            else if (item.buffer_end)
            begin
                emit = 1'b1;
                done = 1'b1;
                st   = ST_SHORT;
                give = 1'b0;
            end
            else if (give)
            begin
                emit = 1'b1;
            end
        end

        // Buffer end restarts everything for the next word
        if (item.buffer_end)
        begin
            sticky_next = 1'b0;
            phase_next  = PH_LEN;
            lbc_next    = 2'd0;
            rem_next    = '0;
            pos_next    = 2'd0;
            fwz_next    = 1'b0;
            ndi_next    = '0;
            pend_next   = ST_OK;
        end

        result.digit_valid = give;
        result.digit_index = give ? idx_use[IDX_W-1:0] : '0;
        result.digit_value = give ? b : 8'h00;
        result.field_done  = done;
        result.status      = done ? st : ST_OK;
    end

    // State update on each consumed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            lbc_reg    <= 2'd0;
            rem_reg    <= '0;
            pos_reg    <= 2'd0;
            fwz_reg    <= 1'b0;
            ndi_reg    <= '0;
            sticky_reg <= 1'b0;
            pend_reg   <= ST_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            lbc_reg    <= lbc_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            fwz_reg    <= fwz_next;
            ndi_reg    <= ndi_next;
            sticky_reg <= sticky_next;
            pend_reg   <= pend_next;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(MAX_DIGITS);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

endmodule

/* src/smd_out_stage.sv */
// Result register for the mpint decoder; decouples the consumer from the parse step.
// Depends on smd_pkg.
module smd_out_stage
    import smd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  smd_ctl_t ctl,
    input  smd_out_t result,
    output logic     slot_free,
    output logic     out_valid,
    input  logic     out_ready,
    output smd_out_t out_word
);

    logic     valid_reg;
    smd_out_t word_reg;

    // Room for a new word when empty or being drained now
    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.step && ctl.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.emit)
        begin
            word_reg <= result;
        end
    end

endmodule

/* src/ssh_mpint_stream_decoder_top.sv */
// Top level of the SSH mpint stream decoder.
// Depends on smd_pkg, smd_in_stage, smd_parse and smd_out_stage.
//
//   Channel  | Signals                          | Direction | Word
//   ---------+----------------------------------+-----------+-----------------------
//   input    | in_valid, in_ready, in_word      | in        | smd_in_t (one byte)
//   output   | out_valid, out_ready, out_word   | out       | smd_out_t (digit/status)
//   config   | cfg_we, cfg_data                 | in        | digit capacity, 10 bits
//
// One byte per cycle sustained unless the output stalls. A byte is decoded in the
// cycle it leaves the input register, and its result word appears the cycle after.
// Bytes that give no result leave no word. Reset clears all control state and sets
// the capacity to 512. A stalled output holds the parse step, which backs up into the
// input register; the input side stays ready while the output register can drain.
module ssh_mpint_stream_decoder_top
    import smd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  smd_in_t          in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output smd_out_t         out_word,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    logic     held_valid;
    smd_in_t  held_word;
    logic     slot_free;
    smd_ctl_t ctl;
    smd_out_t result;
    logic     emit;

    // A held byte is decoded whenever the result register has room
    assign ctl.step = held_valid && slot_free;
    assign ctl.emit = emit;

    smd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .step       (ctl.step),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    smd_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (ctl.step),
        .item     (held_word),
        .emit     (emit),
        .result   (result)
    );

    smd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

/* src/smd_checker.sv */
// Port-level checks for the SSH mpint stream decoder, bound to the top level.
// Depends on smd_pkg and ssh_mpint_stream_decoder_top.
module smd_checker
    import smd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input smd_out_t         out_word
);

    // Every output word carries a digit or a status
    a_word_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.digit_valid || out_word.field_done))
        else $error("output word with neither digit nor status");

    // No status code without an end of field
    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.field_done) |-> (out_word.status == ST_OK))
        else $error("status set without field_done");

    // A digit only closes a field that ends well
    a_digit_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.digit_valid && out_word.field_done)
            |-> (out_word.status == ST_OK))
        else $error("digit delivered with an error status");

    // Empty digit slots read as zero
    a_empty_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.digit_valid)
            |-> (out_word.digit_index == '0 && out_word.digit_value == 8'h00))
        else $error("digit fields not zero without digit_valid");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("stalled output word changed");

endmodule

bind ssh_mpint_stream_decoder_top smd_checker u_smd_checker (.*);
